FILE: rtl/lrp_pkg.sv
package lrp_pkg;

   localparam logic [2:0] OP_WR_ACTION = 3'd0;
   localparam logic [2:0] OP_WR_GOTO   = 3'd1;
   localparam logic [2:0] OP_WR_RULE   = 3'd2;
   localparam logic [2:0] OP_TOKEN     = 3'd3;
   localparam logic [2:0] OP_RESTART   = 3'd4;

   localparam logic [1:0] ACT_EMPTY  = 2'd0;
   localparam logic [1:0] ACT_SHIFT  = 2'd1;
   localparam logic [1:0] ACT_REDUCE = 2'd2;
   localparam logic [1:0] ACT_ACCEPT = 2'd3;

   localparam logic [2:0] EV_SHIFT    = 3'd0;
   localparam logic [2:0] EV_REDUCE   = 3'd1;
   localparam logic [2:0] EV_ACCEPT   = 3'd2;
   localparam logic [2:0] EV_NOACT    = 3'd3;
   localparam logic [2:0] EV_NOGOTO   = 3'd4;
   localparam logic [2:0] EV_STACK    = 3'd5;
   localparam logic [2:0] EV_FINISHED = 3'd6;

   localparam int MAX_RESULTS = 64;

   typedef enum logic [9:0] {
      ST_CLEAR   = 10'b0000000001,
      ST_IDLE    = 10'b0000000010,
      ST_ACT_RD  = 10'b0000000100,
      ST_ACT_EV  = 10'b0000001000,
      ST_RULE_RD = 10'b0000010000,
      ST_RULE_EV = 10'b0000100000,
      ST_TOP_RD  = 10'b0001000000,
      ST_GOTO_RD = 10'b0010000000,
      ST_GOTO_EV = 10'b0100000000,
      ST_STK_RD  = 10'b1000000000
   } state_type;

endpackage

FILE: rtl/lr_table_driven_parse_engine_top.sv
// Channel   Direction  Handshake             Fields
// request   in         start / busy          req_opcode .. req_rule_length
// response  out        rsp_valid strobe      rsp_event_res .. rsp_last
//
// A table write or restart gives no result. A token, unless the parse has finished, keeps
// busy high after its transfer for a registered action read and its decode, and each
// reduction adds a rule read and decode, a stack read, a goto read and decode, and the
// next action read and decode.
// After reset a clearing pass writes every action and goto entry, one a cycle, with busy
// high, over 2**(row bits + wider symbol bits) addresses, 16384 at the default sizes.
// Each result is registered in the cycle after its step, strobed for one cycle, and cannot
// be stalled.
module lr_table_driven_parse_engine_top #(
   parameter int NUM_STATES       = 256,
   parameter int NUM_TERMINALS    = 64,
   parameter int NUM_NONTERMINALS = 64,
   parameter int NUM_RULES        = 256,
   parameter int STACK_DEPTH      = 64,
   parameter int MAX_RULE_LENGTH  = 15
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [2:0] req_opcode,
   input  logic [7:0] req_table_state,
   input  logic [5:0] req_symbol,
   input  logic [1:0] req_action_kind,
   input  logic [7:0] req_target_state,
   input  logic       req_goto_present,
   input  logic [7:0] req_rule_number,
   input  logic [5:0] req_rule_head,
   input  logic [3:0] req_rule_length,
   output logic       rsp_valid,
   output logic [2:0] rsp_event_res,
   output logic [7:0] rsp_top_state,
   output logic [7:0] rsp_reduced_rule,
   output logic [5:0] rsp_reduced_head,
   output logic [6:0] rsp_stack_depth,
   output logic       rsp_last
);

   localparam int SW   = $clog2(NUM_STATES);
   localparam int TW   = $clog2(NUM_TERMINALS);
   localparam int NW   = $clog2(NUM_NONTERMINALS);
   localparam int MW   = (TW > NW) ? TW : NW;
   localparam int AAW  = SW + TW;
   localparam int GAW  = SW + NW;
   localparam int CAW  = SW + MW;
   localparam int RW   = $clog2(NUM_RULES);
   localparam int PW   = $clog2(STACK_DEPTH);
   localparam int SPW  = PW + 1;
   localparam int ML   = (MAX_RULE_LENGTH > 15) ? 15 : MAX_RULE_LENGTH;
   localparam logic [CAW:0] CLR_LAST = (CAW+1)'((1 << CAW) - 1);

   lrp_pkg::state_type state_ff, state_in;

   logic [9:0] action_mem [NUM_STATES*NUM_TERMINALS];
   logic [8:0] goto_mem   [NUM_STATES*NUM_NONTERMINALS];
   logic [9:0] rule_mem   [NUM_RULES];
   logic [9:0] act_rd_ff;
   logic [8:0] goto_rd_ff;
   logic [9:0] rule_rd_ff;

   logic [CAW:0]   clr_ff, clr_in;
   logic [SPW-1:0] sp_ff, sp_in;
   logic           fin_ff, fin_in;
   logic [5:0]     nred_ff, nred_in;
   logic [5:0]     sym_ff, sym_in;
   logic [7:0]     top_ff, top_in;
   logic [7:0]     pay_ff, pay_in;
   logic [5:0]     head_ff, head_in;

   logic        stk_we;
   logic [PW-1:0] stk_wa, stk_ra;
   logic [7:0]  stk_wd, stk_rd;

   logic       ev_v;
   logic [2:0] ev_code;
   logic [7:0] ev_top, ev_rule;
   logic [5:0] ev_head;
   logic [SPW-1:0] ev_sp;
   logic       ev_last;

   logic       accept_req;
   logic [1:0] akind;
   logic [3:0] rlen;

   assign accept_req = start && !busy;
   assign busy = (state_ff != lrp_pkg::ST_IDLE);
   assign akind = act_rd_ff[9:8];
   assign rlen = rule_rd_ff[3:0];

   lrp_stack #(.DEPTH(STACK_DEPTH), .AW(PW)) u_stack (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_wa),
      .wr_data (stk_wd),
      .rd_addr (stk_ra),
      .rd_data (stk_rd)
   );

   // Table memories.
   always_ff @(posedge clock) begin
      if (state_ff == lrp_pkg::ST_CLEAR) begin
         if (32'(clr_ff[CAW-1:MW]) < NUM_STATES && 32'(clr_ff[MW-1:0]) < NUM_TERMINALS) begin
            action_mem[AAW'(clr_ff[CAW-1:MW]) * AAW'(NUM_TERMINALS)
                       + AAW'(clr_ff[MW-1:0])] <= '0;
         end
         if (32'(clr_ff[CAW-1:MW]) < NUM_STATES
             && 32'(clr_ff[MW-1:0]) < NUM_NONTERMINALS) begin
            goto_mem[GAW'(clr_ff[CAW-1:MW]) * GAW'(NUM_NONTERMINALS)
                     + GAW'(clr_ff[MW-1:0])] <= '0;
         end
      end else if (accept_req && req_opcode == lrp_pkg::OP_WR_ACTION) begin
         if (32'(req_table_state) < NUM_STATES && 32'(req_symbol) < NUM_TERMINALS) begin
            action_mem[AAW'(req_table_state) * AAW'(NUM_TERMINALS) + AAW'(req_symbol)] <=
               {req_action_kind,
                (req_action_kind == lrp_pkg::ACT_SHIFT)  ? req_target_state :
                (req_action_kind == lrp_pkg::ACT_REDUCE) ? req_rule_number : 8'd0};
         end
      end else if (accept_req && req_opcode == lrp_pkg::OP_WR_GOTO) begin
         if (32'(req_table_state) < NUM_STATES && 32'(req_symbol) < NUM_NONTERMINALS) begin
            goto_mem[GAW'(req_table_state) * GAW'(NUM_NONTERMINALS) + GAW'(req_symbol)] <=
               req_goto_present ? {1'b1, req_target_state} : 9'd0;
         end
      end
      if (accept_req && req_opcode == lrp_pkg::OP_WR_RULE && 32'(req_rule_number) < NUM_RULES) begin
         rule_mem[RW'(req_rule_number)] <=
            {req_rule_head, (32'(req_rule_length) > ML) ? 4'(ML) : req_rule_length};
      end
      act_rd_ff  <= action_mem[AAW'(top_ff) * AAW'(NUM_TERMINALS) + AAW'(sym_ff)];
      goto_rd_ff <= goto_mem[GAW'(top_ff) * GAW'(NUM_NONTERMINALS) + GAW'(head_ff)];
      rule_rd_ff <= rule_mem[RW'(pay_ff)];
   end

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      sp_in = sp_ff;
      fin_in = fin_ff;
      nred_in = nred_ff;
      sym_in = sym_ff;
      top_in = top_ff;
      pay_in = pay_ff;
      head_in = head_ff;
      stk_we = 1'b0;
      stk_wa = PW'(sp_ff);
      stk_wd = 8'd0;
      stk_ra = PW'(sp_ff - SPW'(1));
      ev_v = 1'b0;
      ev_code = lrp_pkg::EV_SHIFT;
      ev_top = top_ff;
      ev_rule = 8'd0;
      ev_head = 6'd0;
      ev_sp = sp_ff;
      ev_last = 1'b1;
      unique case (state_ff)
         lrp_pkg::ST_CLEAR: begin
            stk_we = 1'b1;
            stk_wa = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CLR_LAST) begin
               state_in = lrp_pkg::ST_IDLE;
            end
         end
         lrp_pkg::ST_IDLE: begin
            if (accept_req) begin
               if (req_opcode == lrp_pkg::OP_RESTART) begin
                  sp_in = SPW'(1);
                  fin_in = 1'b0;
                  top_in = 8'd0;
                  stk_we = 1'b1;
                  stk_wa = '0;
               end else if (req_opcode == lrp_pkg::OP_TOKEN) begin
                  if (fin_ff) begin
                     ev_v = 1'b1;
                     ev_code = lrp_pkg::EV_FINISHED;
                  end else begin
                     sym_in = req_symbol;
                     nred_in = 6'd0;
                     state_in = lrp_pkg::ST_ACT_RD;
                  end
               end
            end
         end
         lrp_pkg::ST_ACT_RD: begin
            state_in = lrp_pkg::ST_ACT_EV;
         end
         lrp_pkg::ST_ACT_EV: begin
            state_in = lrp_pkg::ST_IDLE;
            pay_in = act_rd_ff[7:0];
            if (32'(sym_ff) >= NUM_TERMINALS || 32'(top_ff) >= NUM_STATES
                || akind == lrp_pkg::ACT_EMPTY) begin
               ev_v = 1'b1; ev_code = lrp_pkg::EV_NOACT; fin_in = 1'b1;
            end else if (akind == lrp_pkg::ACT_ACCEPT) begin
               ev_v = 1'b1; ev_code = lrp_pkg::EV_ACCEPT; fin_in = 1'b1;
            end else if (akind == lrp_pkg::ACT_SHIFT) begin
               ev_v = 1'b1;
               if (32'(sp_ff) >= STACK_DEPTH) begin
                  ev_code = lrp_pkg::EV_STACK; fin_in = 1'b1;
               end else begin
                  stk_we = 1'b1;
                  stk_wd = act_rd_ff[7:0];
                  sp_in = sp_ff + 1'b1;
                  top_in = act_rd_ff[7:0];
                  ev_code = lrp_pkg::EV_SHIFT;
                  ev_top = act_rd_ff[7:0];
                  ev_sp = sp_ff + 1'b1;
               end
            end else if (32'(act_rd_ff[7:0]) >= NUM_RULES) begin
               ev_v = 1'b1; ev_code = lrp_pkg::EV_NOACT; fin_in = 1'b1;
            end else if (32'(nred_ff) >= lrp_pkg::MAX_RESULTS - 1) begin
               ev_v = 1'b1; ev_code = lrp_pkg::EV_STACK; fin_in = 1'b1;
            end else begin
               state_in = lrp_pkg::ST_RULE_RD;
            end
         end
         lrp_pkg::ST_RULE_RD: begin
            state_in = lrp_pkg::ST_RULE_EV;
         end
         lrp_pkg::ST_RULE_EV: begin
            head_in = rule_rd_ff[9:4];
            if (SPW'(rlen) >= sp_ff || 32'(rlen) >= STACK_DEPTH) begin
               ev_v = 1'b1; ev_code = lrp_pkg::EV_STACK; fin_in = 1'b1;
               state_in = lrp_pkg::ST_IDLE;
            end else begin
               sp_in = sp_ff - SPW'(rlen);
               stk_ra = PW'(sp_ff - SPW'(rlen) - SPW'(1));
               state_in = lrp_pkg::ST_TOP_RD;
            end
         end
         lrp_pkg::ST_TOP_RD: begin
            top_in = stk_rd;
            state_in = lrp_pkg::ST_GOTO_RD;
         end
         lrp_pkg::ST_GOTO_RD: begin
            state_in = lrp_pkg::ST_GOTO_EV;
         end
         lrp_pkg::ST_GOTO_EV: begin
            state_in = lrp_pkg::ST_IDLE;
            if (32'(head_ff) >= NUM_NONTERMINALS || 32'(top_ff) >= NUM_STATES
                || !goto_rd_ff[8]) begin
               ev_v = 1'b1; ev_code = lrp_pkg::EV_NOGOTO; fin_in = 1'b1;
            end else if (32'(sp_ff) >= STACK_DEPTH) begin
               ev_v = 1'b1; ev_code = lrp_pkg::EV_STACK; fin_in = 1'b1;
            end else begin
               stk_we = 1'b1;
               stk_wd = goto_rd_ff[7:0];
               sp_in = sp_ff + 1'b1;
               top_in = goto_rd_ff[7:0];
               nred_in = nred_ff + 1'b1;
               ev_v = 1'b1;
               ev_code = lrp_pkg::EV_REDUCE;
               ev_top = goto_rd_ff[7:0];
               ev_sp = sp_ff + 1'b1;
               ev_rule = pay_ff;
               ev_head = head_ff;
               ev_last = 1'b0;
               state_in = lrp_pkg::ST_ACT_RD;
            end
         end
         lrp_pkg::ST_STK_RD: begin
            state_in = lrp_pkg::ST_IDLE;
         end
         default: begin
            state_in = lrp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lrp_pkg::ST_CLEAR;
         clr_ff <= '0;
         sp_ff <= SPW'(1);
         fin_ff <= 1'b0;
         nred_ff <= 6'd0;
         top_ff <= 8'd0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         sp_ff <= sp_in;
         fin_ff <= fin_in;
         nred_ff <= nred_in;
         top_ff <= top_in;
         rsp_valid <= ev_v;
      end
      sym_ff <= sym_in;
      pay_ff <= pay_in;
      head_ff <= head_in;
      rsp_event_res <= ev_code;
      rsp_top_state <= ev_top;
      rsp_reduced_rule <= ev_rule;
      rsp_reduced_head <= ev_head;
      rsp_stack_depth <= 7'(ev_sp);
      rsp_last <= ev_last;
   end

   a_sp_range: assert property (@(posedge clock) disable iff (reset)
      sp_ff >= SPW'(1) && 32'(sp_ff) <= STACK_DEPTH) else $error("stack pointer out of range");
   a_busy_no_rsp_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy) else $error("reduce without continuation");
   a_fin_after_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res != lrp_pkg::EV_SHIFT && rsp_event_res != lrp_pkg::EV_REDUCE
      |-> fin_ff) else $error("parse not finished after terminal event");

endmodule

FILE: rtl/lrp_stack.sv
module lrp_stack #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic         clock,
   input  logic         wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]   wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]   rd_data
);

   logic [7:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: verif/lr_parse_checker.sv
`timescale 1ns / 1ps

module lr_parse_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       busy,
   input  logic [2:0] req_opcode,
   input  logic [7:0] req_table_state,
   input  logic [5:0] req_symbol,
   input  logic [1:0] req_action_kind,
   input  logic [7:0] req_target_state,
   input  logic       req_goto_present,
   input  logic [7:0] req_rule_number,
   input  logic [5:0] req_rule_head,
   input  logic [3:0] req_rule_length,
   input  logic       rsp_valid,
   input  logic [2:0] rsp_event_res,
   input  logic [7:0] rsp_top_state,
   input  logic [7:0] rsp_reduced_rule,
   input  logic [5:0] rsp_reduced_head,
   input  logic [6:0] rsp_stack_depth,
   input  logic       rsp_last,
   output int         fail_count,
   output int         pending
);

   typedef struct packed {
      logic [2:0] event_res;
      logic [7:0] top_state;
      logic [7:0] reduced_rule;
      logic [5:0] reduced_head;
      logic [6:0] stack_depth;
      logic       last;
   } parse_event_type;

   logic [9:0] action_tbl [256][64];
   logic [8:0] goto_tbl [256][64];
   logic [9:0] rule_tbl [256];
   logic [7:0] state_stk [64];
   int unsigned depth;
   logic finished;
   parse_event_type expected_events[$];

   function automatic void note_event(logic [2:0] ev, logic [7:0] rule, logic [5:0] head,
                                      logic last);
      parse_event_type e;
      e.event_res = ev;
      e.top_state = state_stk[depth - 1];
      e.reduced_rule = rule;
      e.reduced_head = head;
      e.stack_depth = depth[6:0];
      e.last = last;
      expected_events = {expected_events, e};
   endfunction

   function automatic void parse_token(logic [5:0] sym);
      int n;
      logic [7:0] st;
      logic [9:0] act;
      logic [9:0] rule;
      logic [8:0] go;
      n = 0;
      if (finished) begin
         note_event(lrp_pkg::EV_FINISHED, 8'd0, 6'd0, 1'b1);
         return;
      end
      while (1) begin
         st = state_stk[depth - 1];
         act = action_tbl[st][sym];
         if (act[9:8] == lrp_pkg::ACT_EMPTY) begin
            finished = 1'b1;
            note_event(lrp_pkg::EV_NOACT, 8'd0, 6'd0, 1'b1);
            return;
         end
         if (act[9:8] == lrp_pkg::ACT_ACCEPT) begin
            finished = 1'b1;
            note_event(lrp_pkg::EV_ACCEPT, 8'd0, 6'd0, 1'b1);
            return;
         end
         if (act[9:8] == lrp_pkg::ACT_SHIFT) begin
            if (depth >= 64) begin
               finished = 1'b1;
               note_event(lrp_pkg::EV_STACK, 8'd0, 6'd0, 1'b1);
               return;
            end
            state_stk[depth] = act[7:0];
            depth++;
            note_event(lrp_pkg::EV_SHIFT, 8'd0, 6'd0, 1'b1);
            return;
         end
         if (n >= lrp_pkg::MAX_RESULTS - 1) begin
            finished = 1'b1;
            note_event(lrp_pkg::EV_STACK, 8'd0, 6'd0, 1'b1);
            return;
         end
         rule = rule_tbl[act[7:0]];
         if (rule[3:0] >= depth) begin
            finished = 1'b1;
            note_event(lrp_pkg::EV_STACK, 8'd0, 6'd0, 1'b1);
            return;
         end
         depth -= rule[3:0];
         go = goto_tbl[state_stk[depth - 1]][rule[9:4]];
         if (!go[8]) begin
            finished = 1'b1;
            note_event(lrp_pkg::EV_NOGOTO, 8'd0, 6'd0, 1'b1);
            return;
         end
         if (depth >= 64) begin
            finished = 1'b1;
            note_event(lrp_pkg::EV_STACK, 8'd0, 6'd0, 1'b1);
            return;
         end
         state_stk[depth] = go[7:0];
         depth++;
         note_event(lrp_pkg::EV_REDUCE, act[7:0], rule[9:4], 1'b0);
         n++;
      end
   endfunction

   function automatic void restart_parse();
      for (int i = 0; i < 64; i++) state_stk[i] = 8'd0;
      depth = 1;
      finished = 1'b0;
   endfunction

   always @(posedge clock) begin
      parse_event_type e;
      if (reset) begin
         for (int s = 0; s < 256; s++) begin
            for (int y = 0; y < 64; y++) begin
               action_tbl[s][y] = 10'd0;
               goto_tbl[s][y] = 9'd0;
            end
            rule_tbl[s] = 10'd0;
         end
         restart_parse();
         expected_events.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid) begin
            if (expected_events.size() == 0) begin
               $display("%0t: unexpected result event %0d top %0d depth %0d", $time,
                        rsp_event_res, rsp_top_state, rsp_stack_depth);
               fail_count++;
            end else begin
               e = expected_events.pop_front();
               if (rsp_event_res !== e.event_res) begin
                  $display("%0t: event expected %0d actual %0d", $time, e.event_res,
                           rsp_event_res);
                  fail_count++;
               end
               if (rsp_top_state !== e.top_state) begin
                  $display("%0t: top_state expected %0d actual %0d", $time, e.top_state,
                           rsp_top_state);
                  fail_count++;
               end
               if (rsp_reduced_rule !== e.reduced_rule) begin
                  $display("%0t: reduced_rule expected %0d actual %0d", $time,
                           e.reduced_rule, rsp_reduced_rule);
                  fail_count++;
               end
               if (rsp_reduced_head !== e.reduced_head) begin
                  $display("%0t: reduced_head expected %0d actual %0d", $time,
                           e.reduced_head, rsp_reduced_head);
                  fail_count++;
               end
               if (rsp_stack_depth !== e.stack_depth) begin
                  $display("%0t: stack_depth expected %0d actual %0d", $time,
                           e.stack_depth, rsp_stack_depth);
                  fail_count++;
               end
               if (rsp_last !== e.last) begin
                  $display("%0t: last expected %0d actual %0d", $time, e.last, rsp_last);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            case (req_opcode)
               lrp_pkg::OP_WR_ACTION: begin
                  action_tbl[req_table_state][req_symbol] = {req_action_kind,
                     (req_action_kind == lrp_pkg::ACT_SHIFT) ? req_target_state :
                     (req_action_kind == lrp_pkg::ACT_REDUCE) ? req_rule_number : 8'd0};
               end
               lrp_pkg::OP_WR_GOTO: begin
                  goto_tbl[req_table_state][req_symbol] =
                     req_goto_present ? {1'b1, req_target_state} : 9'd0;
               end
               lrp_pkg::OP_WR_RULE: rule_tbl[req_rule_number] = {req_rule_head, req_rule_length};
               lrp_pkg::OP_TOKEN: parse_token(req_symbol);
               lrp_pkg::OP_RESTART: restart_parse();
               default: ;
            endcase
         end
      end
      pending = expected_events.size();
   end

endmodule

FILE: verif/lr_table_driven_parse_engine_top_test.sv
`timescale 1ns / 1ps

module lr_table_driven_parse_engine_top_test;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   logic [2:0] req_opcode;
   logic [7:0] req_table_state;
   logic [5:0] req_symbol;
   logic [1:0] req_action_kind;
   logic [7:0] req_target_state;
   logic       req_goto_present;
   logic [7:0] req_rule_number;
   logic [5:0] req_rule_head;
   logic [3:0] req_rule_length;
   logic       rsp_valid;
   logic [2:0] rsp_event_res;
   logic [7:0] rsp_top_state;
   logic [7:0] rsp_reduced_rule;
   logic [5:0] rsp_reduced_head;
   logic [6:0] rsp_stack_depth;
   logic       rsp_last;
   int         fail_count;
   int         pending;

   int         items_sent;
   bit         burst;
   logic [7:0] written_rules[$];

   lr_table_driven_parse_engine_top DUT (.*);

   lr_parse_checker checker_inst (.*);

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   task automatic scramble();
      {req_table_state, req_symbol, req_action_kind, req_target_state} = 24'($urandom);
      {req_goto_present, req_rule_number, req_rule_head, req_rule_length} = 19'($urandom);
   endtask

   task automatic issue();
      int gap;
      gap = burst ? 0 : $urandom_range(0, 12);
      repeat (gap) @(negedge clock);
      start = 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
      start = 1'b0;
      items_sent++;
   endtask

   task automatic write_action(logic [7:0] row, logic [5:0] sym, logic [1:0] kind,
                               logic [7:0] arg);
      scramble();
      req_opcode = lrp_pkg::OP_WR_ACTION;
      req_table_state = row;
      req_symbol = sym;
      req_action_kind = kind;
      if (kind == lrp_pkg::ACT_SHIFT) req_target_state = arg;
      if (kind == lrp_pkg::ACT_REDUCE) req_rule_number = arg;
      issue();
   endtask

   task automatic write_goto(logic [7:0] row, logic [5:0] nt, logic present,
                             logic [7:0] dest);
      scramble();
      req_opcode = lrp_pkg::OP_WR_GOTO;
      req_table_state = row;
      req_symbol = nt;
      req_goto_present = present;
      req_target_state = dest;
      issue();
   endtask

   task automatic write_rule(logic [7:0] slot, logic [5:0] head, logic [3:0] len);
      scramble();
      req_opcode = lrp_pkg::OP_WR_RULE;
      req_rule_number = slot;
      req_rule_head = head;
      req_rule_length = len;
      written_rules = {written_rules, slot};
      issue();
   endtask

   task automatic send_token(logic [5:0] sym);
      scramble();
      req_opcode = lrp_pkg::OP_TOKEN;
      req_symbol = sym;
      issue();
   endtask

   task automatic restart_parse();
      scramble();
      req_opcode = lrp_pkg::OP_RESTART;
      issue();
   endtask

   function automatic logic [7:0] any_rule();
      return written_rules[$urandom_range(0, written_rules.size() - 1)];
   endfunction

   task automatic send_noise();
      scramble();
      req_opcode = 3'($urandom_range(0, 7));
      if (req_opcode == lrp_pkg::OP_WR_ACTION && req_action_kind == lrp_pkg::ACT_REDUCE)
         req_rule_number = any_rule();
      if (req_opcode == lrp_pkg::OP_WR_RULE) written_rules = {written_rules, req_rule_number};
      issue();
   endtask

   task automatic grammar_phase();
      int n;
      int pick;
      repeat ($urandom_range(1, 3))
         write_rule(8'($urandom_range(0, 255)), 6'($urandom_range(0, 3)),
                    4'($urandom_range(0, 3)));
      n = $urandom_range(4, 12);
      repeat (n) begin
         pick = $urandom_range(0, 99);
         if (pick < 40)
            write_action(8'($urandom_range(0, 7)), 6'($urandom_range(0, 3)),
                         lrp_pkg::ACT_SHIFT, 8'($urandom_range(0, 7)));
         else if (pick < 75)
            write_action(8'($urandom_range(0, 7)), 6'($urandom_range(0, 3)),
                         lrp_pkg::ACT_REDUCE, any_rule());
         else if (pick < 85)
            write_action(8'($urandom_range(0, 7)), 6'($urandom_range(0, 3)),
                         lrp_pkg::ACT_ACCEPT, 8'd0);
         else
            write_action(8'($urandom_range(0, 7)), 6'($urandom_range(0, 3)),
                         lrp_pkg::ACT_EMPTY, 8'd0);
      end
      repeat ($urandom_range(3, 10))
         write_goto(8'($urandom_range(0, 7)), 6'($urandom_range(0, 3)),
                    $urandom_range(0, 7) != 0, 8'($urandom_range(0, 7)));
      restart_parse();
      repeat ($urandom_range(4, 20)) begin
         if ($urandom_range(0, 9) == 0) send_token(6'($urandom_range(0, 63)));
         else send_token(6'($urandom_range(0, 3)));
         if ($urandom_range(0, 7) == 0) send_noise();
      end
   endtask

   // A self-loop on one state fills the stack; the next token overflows it either by a
   // shift or by the goto push of an empty rule, and the last token finds the parse finished.
   task automatic overflow_phase();
      write_rule(8'd7, 6'd2, 4'd0);
      write_action(8'd0, 6'd5, lrp_pkg::ACT_SHIFT, 8'd9);
      write_action(8'd9, 6'd5, lrp_pkg::ACT_SHIFT, 8'd9);
      write_action(8'd9, 6'd6, lrp_pkg::ACT_REDUCE, 8'd7);
      write_goto(8'd9, 6'd2, 1'b1, 8'd9);
      restart_parse();
      repeat (63) send_token(6'd5);
      send_token($urandom_range(0, 1) ? 6'd5 : 6'd6);
      send_token(6'd5);
   endtask

   initial begin
      #40_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_opcode = lrp_pkg::OP_TOKEN;
      req_table_state = 8'd0;
      req_symbol = 6'd0;
      req_action_kind = lrp_pkg::ACT_EMPTY;
      req_target_state = 8'd0;
      req_goto_present = 1'b0;
      req_rule_number = 8'd0;
      req_rule_head = 6'd0;
      req_rule_length = 4'd0;
      items_sent = 0;
      burst = 1'b0;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      send_token(6'd0);
      send_token(6'd63);
      restart_parse();
      write_rule(8'd0, 6'd0, 4'd1);
      write_rule(8'd255, 6'd63, 4'd15);
      write_rule(8'd1, 6'd5, 4'd1);
      write_rule(8'd2, 6'd1, 4'd0);
      write_action(8'd0, 6'd0, lrp_pkg::ACT_SHIFT, 8'd1);
      write_action(8'd1, 6'd1, lrp_pkg::ACT_REDUCE, 8'd0);
      write_goto(8'd0, 6'd0, 1'b1, 8'd2);
      write_action(8'd2, 6'd1, lrp_pkg::ACT_ACCEPT, 8'd0);
      write_action(8'd255, 6'd63, lrp_pkg::ACT_ACCEPT, 8'd255);
      write_goto(8'd255, 6'd63, 1'b0, 8'd255);
      send_token(6'd0);
      send_token(6'd1);
      send_token(6'd1);
      restart_parse();
      write_action(8'd0, 6'd63, lrp_pkg::ACT_REDUCE, 8'd255);
      send_token(6'd63);
      restart_parse();
      write_action(8'd1, 6'd2, lrp_pkg::ACT_REDUCE, 8'd1);
      send_token(6'd0);
      send_token(6'd2);
      restart_parse();
      write_action(8'd0, 6'd4, lrp_pkg::ACT_SHIFT, 8'd3);
      write_action(8'd3, 6'd3, lrp_pkg::ACT_REDUCE, 8'd2);
      write_goto(8'd3, 6'd1, 1'b1, 8'd3);
      send_token(6'd4);
      send_token(6'd3);

      while (items_sent < 380) begin
         burst = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 11) == 0) overflow_phase();
         else grammar_phase();
      end
      burst = 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/lrp_pkg.sv
rtl/lrp_stack.sv
rtl/lr_table_driven_parse_engine_top.sv
verif/lr_parse_checker.sv
verif/lr_table_driven_parse_engine_top_test.sv
